// ===== rtl/lof_det_pkg.sv =====
// Shared types and constants of the local outlier factor detector.
package lof_det_pkg;

    localparam int DEF_MAX_POINTS = 256;
    localparam int DEF_MAX_K      = 16;
    localparam int DEF_MAX_DIMS   = 4;
    localparam int DEF_COORD_BITS = 16;

    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int DIST_W     = 24;
    localparam int LOF_W      = 16;

    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TRAIN = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_NEIGHBOR_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVIATION      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIMS_IN_USE    = 2'd2;

    localparam logic [4:0]  RST_NEIGHBOR_COUNT = 5'd5;
    localparam logic [15:0] RST_DEVIATION      = 16'd64;
    localparam logic [2:0]  RST_DIMS_IN_USE    = 3'd4;

    localparam logic [DIST_W-1:0] DIST_SAT = 24'hFFFFFF;
    localparam logic [LOF_W-1:0]  ONE_Q8   = 16'd256;
    localparam logic [LOF_W-1:0]  LOF_SAT  = 16'hFFFF;

    typedef struct packed {
        logic clr;
        logic ins;
    } t_cell_ctl;

endpackage

// ===== rtl/lof_det_if.sv =====
// Valid/ready channel interfaces for detector items and results.
interface lof_in_if #(
    parameter int COORD_BITS = lof_det_pkg::DEF_COORD_BITS
);
    logic                                 valid;
    logic                                 ready;
    logic [lof_det_pkg::KIND_W-1:0]       kind;
    logic                                 labeled_anomaly;
    logic signed [COORD_BITS-1:0]         coord_0;
    logic signed [COORD_BITS-1:0]         coord_1;
    logic signed [COORD_BITS-1:0]         coord_2;
    logic signed [COORD_BITS-1:0]         coord_3;

    modport source (output valid, kind, labeled_anomaly, coord_0, coord_1, coord_2, coord_3,
                    input ready);
    modport sink (input valid, kind, labeled_anomaly, coord_0, coord_1, coord_2, coord_3,
                  output ready);
endinterface

interface lof_out_if;
    logic                          valid;
    logic                          ready;
    logic                          is_outlier;
    logic [lof_det_pkg::LOF_W-1:0] lof_value;

    modport source (output valid, is_outlier, lof_value, input ready);
    modport sink (input valid, is_outlier, lof_value, output ready);
endinterface

// ===== rtl/local_outlier_factor_detector_unit.sv =====
// Top level of the local outlier factor detector: sequencer, stores and neighbor chain.
//
// Items enter on i_in (valid/ready): kind clear empties the store, kind train
// appends the point unless labeled_anomaly is set or the store is full, kind
// query returns one result on o_out: the LOF in Q8.8 and an outlier flag.
// Configuration (k, deviation, dims) is to be written on i_cfg_we/i_cfg_idx/i_cfg_data
// only while the block is idle; the block itself does not enforce this. A query with
// k zero or k not below the point count skips the scans and returns an LOF of one.
// Otherwise one query runs n+k+1 neighbor scans over the n stored points, each
// candidate taking a fetch, one 16x16 multiply and one add per dimension, then
// 24 square-root steps; the reach sums over k neighbors and the divisions follow.
// One item is worked on at a time; i_in.ready is high only when idle.
// Reset empties the store and loads k=5, deviation=64, dims=4; no clearing
// pass is needed. A finished result waits in the output register; while the
// receiver stalls, the block holds the next query's result until taken.
module local_outlier_factor_detector_unit #(
    parameter int MAX_POINTS = lof_det_pkg::DEF_MAX_POINTS,
    parameter int MAX_K      = lof_det_pkg::DEF_MAX_K,
    parameter int MAX_DIMS   = lof_det_pkg::DEF_MAX_DIMS,
    parameter int COORD_BITS = lof_det_pkg::DEF_COORD_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    lof_in_if.sink                                i_in,
    lof_out_if.source                             o_out,
    input  logic                                  i_cfg_we,
    input  logic [lof_det_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [lof_det_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import lof_det_pkg::*;

    localparam int AW    = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int KW    = $clog2(MAX_K + 1);
    localparam int KIW   = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int PW    = MAX_DIMS * COORD_BITS;
    localparam int SUM_W = DIST_W + KW;
    localparam int NUM_W = SUM_W + 8;
    localparam int TOT_W = NUM_W + KW;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_CLDA   = 5'd1;
    localparam logic [4:0] S_CLDW   = 5'd2;
    localparam logic [4:0] S_CLDL   = 5'd3;
    localparam logic [4:0] S_SINIT  = 5'd4;
    localparam logic [4:0] S_RD     = 5'd5;
    localparam logic [4:0] S_RDW    = 5'd6;
    localparam logic [4:0] S_DST    = 5'd7;
    localparam logic [4:0] S_DWT    = 5'd8;
    localparam logic [4:0] S_SDONE  = 5'd9;
    localparam logic [4:0] S_RSA    = 5'd10;
    localparam logic [4:0] S_RSW    = 5'd11;
    localparam logic [4:0] S_RSADD  = 5'd12;
    localparam logic [4:0] S_RSEND  = 5'd13;
    localparam logic [4:0] S_CNEXT  = 5'd14;
    localparam logic [4:0] S_DIVS   = 5'd15;
    localparam logic [4:0] S_DIVW   = 5'd16;
    localparam logic [4:0] S_FIN    = 5'd17;

    localparam logic [1:0] PH_A = 2'd0;   // k-distance of every stored point
    localparam logic [1:0] PH_B = 2'd1;   // neighbors of the query
    localparam logic [1:0] PH_C = 2'd2;   // neighbors of each query neighbor
    localparam logic [1:0] PH_F = 2'd3;   // final average

    // configuration
    logic [4:0]        r_nc;
    logic [15:0]       r_dev;
    logic [2:0]        r_dims;

    logic [4:0]        r_state;
    logic [1:0]        r_phase;
    logic [CNT_W-1:0]  r_cnt;
    logic [PW-1:0]     r_query;
    logic [PW-1:0]     r_ctr;
    logic [KW-1:0]     r_k;
    logic [2:0]        r_deff;
    logic [CNT_W-1:0]  r_i;
    logic [CNT_W-1:0]  r_j;
    logic [KW-1:0]     r_m;
    logic [KW-1:0]     r_o;
    logic [AW-1:0]     r_skip;
    logic              r_skip_en;
    logic [AW-1:0]     r_addr;
    logic [PW-1:0]     r_rdata;
    logic [AW-1:0]     r_kaddr;
    logic [DIST_W-1:0] r_kd;
    logic [SUM_W-1:0]  r_sum;
    logic [SUM_W-1:0]  r_sq;
    logic [TOT_W-1:0]  r_tot;
    logic [LOF_W-1:0]  r_lof;
    logic [AW-1:0]     r_qidx [MAX_K];
    logic              r_out_valid;
    logic              r_out_flag;
    logic [LOF_W-1:0]  r_out_lof;

    logic [PW-1:0]     mem_pts [MAX_POINTS];
    logic [DIST_W-1:0] mem_kd  [MAX_POINTS];

    logic [MAX_K-1:0]  c_valid;
    logic [MAX_K-1:0]  c_gt;
    logic [DIST_W-1:0] c_dist [MAX_K];
    logic [AW-1:0]     c_idx  [MAX_K];
    t_cell_ctl         cell_ctl;

    logic              dist_done;
    logic [DIST_W-1:0] dist_val;
    logic              div_done;
    logic [TOT_W-1:0]  div_quot;
    logic [TOT_W-1:0]  div_num;
    logic [SUM_W-1:0]  div_den;

    logic [COORD_BITS-1:0] coord_in [4];
    logic [PW-1:0]     pt_in;
    logic [KW-1:0]     k_eff;
    logic [2:0]        d_eff;
    logic              accept;
    logic              kd_we;
    logic              pt_we;
    logic [DIST_W-1:0] kth_dist;
    logic [DIST_W-1:0] reach;
    logic signed [17:0] lof_s;
    logic signed [17:0] lo_b;
    logic signed [17:0] hi_b;
    logic              flag;

    always_comb begin
        coord_in[0] = i_in.coord_0;
        coord_in[1] = i_in.coord_1;
        coord_in[2] = i_in.coord_2;
        coord_in[3] = i_in.coord_3;
        for (int d = 0; d < MAX_DIMS; d++) begin
            pt_in[d*COORD_BITS +: COORD_BITS] = coord_in[d];
        end
        k_eff = (7'(r_nc) > 7'(MAX_K)) ? KW'(MAX_K) : KW'(r_nc);
        if (r_dims == 3'd0) d_eff = 3'd1;
        else if (4'(r_dims) > 4'(MAX_DIMS)) d_eff = 3'(MAX_DIMS);
        else d_eff = r_dims;
    end

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign pt_we      = accept && (i_in.kind == KIND_TRAIN) && !i_in.labeled_anomaly
                        && (r_cnt != CNT_W'(MAX_POINTS));
    assign kd_we      = (r_state == S_SDONE) && (r_phase == PH_A);
    assign kth_dist   = c_dist[KIW'(r_k - 1'b1)];
    assign reach      = (c_dist[r_m[KIW-1:0]] > r_kd) ? c_dist[r_m[KIW-1:0]] : r_kd;

    assign cell_ctl.clr = (r_state == S_SINIT);
    assign cell_ctl.ins = (r_state == S_DWT) && dist_done;

    // point store and k-distance store
    always_ff @(posedge i_clk) begin
        if (pt_we) mem_pts[r_cnt[AW-1:0]] <= pt_in;
        r_rdata <= mem_pts[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (kd_we) mem_kd[r_i[AW-1:0]] <= kth_dist;
        r_kd <= mem_kd[r_kaddr];
    end

    // neighbor chain
    for (genvar g = 0; g < MAX_K; g++) begin : g_cell
        logic              p_valid;
        logic [DIST_W-1:0] p_dist;
        logic [AW-1:0]     p_idx;
        logic              p_gt;
        if (g == 0) begin : g_head
            assign p_valid = 1'b0;
            assign p_dist  = '0;
            assign p_idx   = '0;
            assign p_gt    = 1'b0;
        end else begin : g_body
            assign p_valid = c_valid[g-1];
            assign p_dist  = c_dist[g-1];
            assign p_idx   = c_idx[g-1];
            assign p_gt    = c_gt[g-1];
        end
        lof_det_cell #(.IDX_W(AW)) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (cell_ctl),
            .i_active     (KW'(g) < r_k),
            .i_cand_dist  (dist_val),
            .i_cand_idx   (r_j[AW-1:0]),
            .i_prev_valid (p_valid),
            .i_prev_dist  (p_dist),
            .i_prev_idx   (p_idx),
            .i_prev_gt    (p_gt),
            .o_valid      (c_valid[g]),
            .o_dist       (c_dist[g]),
            .o_idx        (c_idx[g]),
            .o_gt         (c_gt[g])
        );
    end

    lof_det_dist #(.COORD_BITS(COORD_BITS), .MAX_DIMS(MAX_DIMS)) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DST),
        .i_dims  (r_deff),
        .i_a     (r_ctr),
        .i_b     (r_rdata),
        .o_done  (dist_done),
        .o_dist  (dist_val)
    );

    assign div_num = (r_phase == PH_C) ? TOT_W'({r_sq, 8'd0}) : r_tot;
    assign div_den = (r_phase == PH_C) ? r_sum : SUM_W'(r_k);

    lof_det_div #(.NW(TOT_W), .DW(SUM_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DIVS),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        lof_s = 18'(r_lof);
        lo_b  = 18'(ONE_Q8) - 18'(r_dev);
        hi_b  = 18'(ONE_Q8) + 18'(r_dev);
        flag  = (lof_s < lo_b) || (lof_s > hi_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nc        <= RST_NEIGHBOR_COUNT;
            r_dev       <= RST_DEVIATION;
            r_dims      <= RST_DIMS_IN_USE;
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_query     <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_NEIGHBOR_COUNT: r_nc   <= i_cfg_data[4:0];
                    CFG_DEVIATION:      r_dev  <= i_cfg_data;
                    CFG_DIMS_IN_USE:    r_dims <= i_cfg_data[2:0];
                    default: ;
                endcase
            end
            if (r_state == S_FIN && (!r_out_valid || o_out.ready)) r_out_valid <= 1'b1;
            else if (o_out.ready) r_out_valid <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        case (i_in.kind)
                            KIND_CLEAR: r_cnt <= '0;
                            KIND_TRAIN: if (pt_we) r_cnt <= r_cnt + 1'b1;
                            KIND_QUERY: begin
                                r_query <= pt_in;
                                r_k     <= k_eff;
                                r_deff  <= d_eff;
                                r_tot   <= '0;
                                if (k_eff == '0
                                    || (CNT_W + KW)'(k_eff) >= (CNT_W + KW)'(r_cnt)) begin
                                    r_lof   <= ONE_Q8;
                                    r_state <= S_FIN;
                                end else begin
                                    r_phase   <= PH_A;
                                    r_i       <= '0;
                                    r_skip_en <= 1'b1;
                                    r_state   <= S_CLDA;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_CLDA: begin
                    r_addr  <= r_i[AW-1:0];
                    r_skip  <= r_i[AW-1:0];
                    r_state <= S_CLDW;
                end
                S_CLDW: r_state <= S_CLDL;
                S_CLDL: begin
                    r_ctr   <= r_rdata;
                    r_state <= S_SINIT;
                end
                S_SINIT: begin
                    r_j     <= '0;
                    r_state <= S_RD;
                end
                S_RD: begin
                    if (r_j == r_cnt) begin
                        r_state <= S_SDONE;
                    end else if (r_skip_en && r_j[AW-1:0] == r_skip) begin
                        r_j <= r_j + 1'b1;
                    end else begin
                        r_addr  <= r_j[AW-1:0];
                        r_state <= S_RDW;
                    end
                end
                S_RDW: r_state <= S_DST;
                S_DST: r_state <= S_DWT;
                S_DWT: begin
                    if (dist_done) begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_SDONE: begin
                    r_m   <= '0;
                    r_sum <= '0;
                    case (r_phase)
                        PH_A: begin
                            if (r_i == r_cnt - 1'b1) begin
                                r_ctr     <= r_query;
                                r_skip_en <= 1'b0;
                                r_phase   <= PH_B;
                                r_state   <= S_SINIT;
                            end else begin
                                r_i     <= r_i + 1'b1;
                                r_state <= S_CLDA;
                            end
                        end
                        PH_B: begin
                            for (int g = 0; g < MAX_K; g++) r_qidx[g] <= c_idx[g];
                            r_state <= S_RSA;
                        end
                        default: r_state <= S_RSA;
                    endcase
                end
                S_RSA: begin
                    r_kaddr <= c_idx[r_m[KIW-1:0]];
                    r_state <= S_RSW;
                end
                S_RSW: r_state <= S_RSADD;
                S_RSADD: begin
                    r_sum <= r_sum + SUM_W'(reach);
                    if (r_m == r_k - 1'b1) begin
                        r_state <= S_RSEND;
                    end else begin
                        r_m     <= r_m + 1'b1;
                        r_state <= S_RSA;
                    end
                end
                S_RSEND: begin
                    if (r_phase == PH_B) begin
                        r_sq    <= r_sum;
                        r_o     <= '0;
                        r_state <= S_CNEXT;
                    end else if (r_sum == '0) begin
                        if (r_sq != '0) begin
                            r_lof   <= LOF_SAT;
                            r_state <= S_FIN;
                        end else begin
                            r_tot   <= r_tot + TOT_W'(ONE_Q8);
                            r_o     <= r_o + 1'b1;
                            r_state <= S_CNEXT;
                        end
                    end else begin
                        r_state <= S_DIVS;
                    end
                end
                S_CNEXT: begin
                    if (r_o == r_k) begin
                        r_phase <= PH_F;
                        r_state <= S_DIVS;
                    end else begin
                        r_addr    <= r_qidx[r_o[KIW-1:0]];
                        r_skip    <= r_qidx[r_o[KIW-1:0]];
                        r_skip_en <= 1'b1;
                        r_phase   <= PH_C;
                        r_state   <= S_CLDW;
                    end
                end
                S_DIVS: r_state <= S_DIVW;
                S_DIVW: begin
                    if (div_done) begin
                        if (r_phase == PH_C) begin
                            r_tot   <= r_tot + div_quot;
                            r_o     <= r_o + 1'b1;
                            r_state <= S_CNEXT;
                        end else begin
                            r_lof   <= (div_quot > TOT_W'(LOF_SAT)) ? LOF_SAT
                                                                    : div_quot[LOF_W-1:0];
                            r_state <= S_FIN;
                        end
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_lof   <= r_lof;
                        r_out_flag  <= flag;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.is_outlier = r_out_flag;
    assign o_out.lof_value  = r_out_lof;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_POINTS))
        else $error("point count beyond capacity");

    a_list_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SDONE && r_phase == PH_A) |-> ($countones(c_valid) == int'(r_k)))
        else $error("neighbor chain not exactly k deep after scan");

    a_reach_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RSA) |-> c_valid[r_m[KIW-1:0]])
        else $error("reach sum reads an empty neighbor slot");

    a_one_inlier: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.lof_value == ONE_Q8) |-> !o_out.is_outlier)
        else $error("LOF of one flagged as outlier");

endmodule

// ===== rtl/lof_det_dist.sv =====
// Euclidean distance unit: one square per dimension, then a bit-serial square root.
module lof_det_dist #(
    parameter int COORD_BITS = lof_det_pkg::DEF_COORD_BITS,
    parameter int MAX_DIMS   = lof_det_pkg::DEF_MAX_DIMS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [2:0]                          i_dims,
    input  logic [MAX_DIMS*COORD_BITS-1:0]      i_a,
    input  logic [MAX_DIMS*COORD_BITS-1:0]      i_b,
    output logic                                o_done,
    output logic [lof_det_pkg::DIST_W-1:0]      o_dist
);
    import lof_det_pkg::*;

    localparam int PW    = MAX_DIMS * COORD_BITS;
    localparam int DIW   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int MAG_W = COORD_BITS + 1;
    localparam int EXT_W = (MAG_W > 17) ? MAG_W : 17;

    localparam logic [2:0] D_IDLE = 3'd0;
    localparam logic [2:0] D_MUL  = 3'd1;
    localparam logic [2:0] D_ADD  = 3'd2;
    localparam logic [2:0] D_RINI = 3'd3;
    localparam logic [2:0] D_ROOT = 3'd4;
    localparam logic [2:0] D_DONE = 3'd5;

    logic [2:0]            r_state;
    logic [PW-1:0]         r_a;
    logic [PW-1:0]         r_b;
    logic [2:0]            r_n;
    logic [DIW-1:0]        r_d;
    logic                  r_sat;
    logic [31:0]           r_sq;
    logic [33:0]           r_acc;
    logic [47:0]           r_x;
    logic [47:0]           r_res;
    logic [47:0]           r_bit;
    logic [4:0]            r_stp;

    logic signed [COORD_BITS-1:0] a_c;
    logic signed [COORD_BITS-1:0] b_c;
    logic signed [MAG_W-1:0]      diff;
    logic [MAG_W-1:0]             mag;
    logic [EXT_W-1:0]             mag_x;
    logic [48:0]                  trial;

    always_comb begin
        a_c   = r_a[int'(r_d)*COORD_BITS +: COORD_BITS];
        b_c   = r_b[int'(r_d)*COORD_BITS +: COORD_BITS];
        diff  = MAG_W'(a_c) - MAG_W'(b_c);
        mag   = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
        mag_x = EXT_W'(mag);
        trial = {1'b0, r_res} + {1'b0, r_bit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
        end else begin
            case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_a     <= i_a;
                        r_b     <= i_b;
                        r_n     <= i_dims;
                        r_d     <= '0;
                        r_sat   <= 1'b0;
                        r_acc   <= '0;
                        r_state <= D_MUL;
                    end
                end
                D_MUL: begin
                    if (|mag_x[EXT_W-1:16]) r_sat <= 1'b1;
                    r_sq    <= mag_x[15:0] * mag_x[15:0];
                    r_state <= D_ADD;
                end
                D_ADD: begin
                    r_acc <= r_acc + 34'(r_sq);
                    if (3'(r_d) + 3'd1 == r_n) begin
                        r_state <= D_RINI;
                    end else begin
                        r_d     <= r_d + 1'b1;
                        r_state <= D_MUL;
                    end
                end
                D_RINI: begin
                    if (r_sat || (|r_acc[33:32])) begin
                        r_res   <= 48'(DIST_SAT);
                        r_state <= D_DONE;
                    end else begin
                        r_x     <= {r_acc[31:0], 16'd0};
                        r_res   <= '0;
                        r_bit   <= 48'h1 << 46;
                        r_stp   <= 5'd23;
                        r_state <= D_ROOT;
                    end
                end
                D_ROOT: begin
                    if ({1'b0, r_x} >= trial) begin
                        r_x   <= r_x - trial[47:0];
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_stp == 5'd0) r_state <= D_DONE;
                    else r_stp <= r_stp - 1'b1;
                end
                D_DONE:  r_state <= D_IDLE;
                default: r_state <= D_IDLE;
            endcase
        end
    end

    assign o_done = (r_state == D_DONE);
    assign o_dist = r_res[DIST_W-1:0];

endmodule

// ===== rtl/lof_det_div.sv =====
// Restoring divider, one quotient bit per cycle.
module lof_det_div #(
    parameter int NW = 42,
    parameter int DW = 29
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quot
);
    localparam int CW = $clog2(NW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_q;
    logic [DW:0]   r_rem;
    logic [DW-1:0] r_den;
    logic [DW:0]   rem_sh;
    logic          take;

    always_comb begin
        rem_sh = {r_rem[DW-1:0], r_q[NW-1]};
        take   = (rem_sh >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == CW'(1));
            if (i_start) begin
                r_q    <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_cnt  <= CW'(NW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= take ? (rem_sh - {1'b0, r_den}) : rem_sh;
                r_q   <= {r_q[NW-2:0], take};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) r_busy <= 1'b0;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== rtl/lof_det_cell.sv =====
// One slot of the sorted nearest-neighbor chain; shifts toward the tail on insert.
module lof_det_cell #(
    parameter int IDX_W = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  lof_det_pkg::t_cell_ctl           i_ctl,
    input  logic                             i_active,
    input  logic [lof_det_pkg::DIST_W-1:0]   i_cand_dist,
    input  logic [IDX_W-1:0]                 i_cand_idx,
    input  logic                             i_prev_valid,
    input  logic [lof_det_pkg::DIST_W-1:0]   i_prev_dist,
    input  logic [IDX_W-1:0]                 i_prev_idx,
    input  logic                             i_prev_gt,
    output logic                             o_valid,
    output logic [lof_det_pkg::DIST_W-1:0]   o_dist,
    output logic [IDX_W-1:0]                 o_idx,
    output logic                             o_gt
);
    import lof_det_pkg::*;

    logic              r_valid;
    logic [DIST_W-1:0] r_dist;
    logic [IDX_W-1:0]  r_idx;

    // strictly greater keeps equal distances in arrival order
    assign o_gt = i_active && (!r_valid || (r_dist > i_cand_dist));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.clr) begin
            r_valid <= 1'b0;
        end else if (i_ctl.ins && o_gt) begin
            if (i_prev_gt) begin
                r_valid <= i_prev_valid;
                r_dist  <= i_prev_dist;
                r_idx   <= i_prev_idx;
            end else begin
                r_valid <= 1'b1;
                r_dist  <= i_cand_dist;
                r_idx   <= i_cand_idx;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_dist  = r_dist;
    assign o_idx   = r_idx;

endmodule

// ===== test/local_outlier_factor_detector_unit_tb.sv =====
// Self-checking testbench of the local outlier factor detector unit.
`timescale 1ns / 100ps

module local_outlier_factor_detector_unit_tb;
    import lof_det_pkg::*;

    localparam int  NPTS      = DEF_MAX_POINTS;
    localparam int  KMAX      = DEF_MAX_K;
    localparam int  CYCLE_CAP = 6000000;
    localparam int  SETTLE    = 60;

    typedef logic [63:0] t_point;

    typedef struct packed {
        logic             outlier;
        logic [LOF_W-1:0] lof;
    } t_lof_result;

    class t_lof_scoreboard;
        t_lof_result pending[$];
        int          errors;

        function new();
            errors = 0;
        endfunction

        function void note_query(t_lof_result r);
            pending = {pending, r};
        endfunction

        function void check_result(logic outlier, logic [LOF_W-1:0] lof);
            t_lof_result want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: outlier=%0d lof=%h", outlier, lof);
                return;
            end
            want = pending.pop_front();
            if (want.outlier !== outlier || want.lof !== lof) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected outlier=%0d lof=%h, got outlier=%0d lof=%h",
                             want.outlier, want.lof, outlier, lof);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    lof_in_if  in_ch();
    lof_out_if out_ch();

    local_outlier_factor_detector_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    t_lof_scoreboard sb;
    int src_idle;
    int snk_idle;
    int cycles;

    // predictor state
    logic [4:0]  k_reg;
    logic [15:0] dev_reg;
    logic [2:0]  dims_reg;
    t_point      store[NPTS];
    int          n_stored;
    t_point      query_pt;
    int unsigned kdist[NPTS];
    int          near_idx[KMAX];
    int unsigned near_d[KMAX];

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(99) < snk_idle) ? 1'b0 : 1'b1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.is_outlier, out_ch.lof_value);
    end

    function automatic int dims_eff();
        if (dims_reg == 0) return 1;
        if (dims_reg > DEF_MAX_DIMS) return DEF_MAX_DIMS;
        return int'(dims_reg);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic int unsigned point_dist(t_point a, t_point b);
        longint unsigned sum;
        longint unsigned mag;
        longint          diff;
        sum = 0;
        for (int d = 0; d < dims_eff(); d++) begin
            diff = longint'($signed(a[16*d +: 16])) - longint'($signed(b[16*d +: 16]));
            mag  = (diff < 0) ? longint'(-diff) : longint'(diff);
            if (mag >= 65536) return int'(DIST_SAT);
            sum += mag * mag;
        end
        if (sum >= (64'd1 << 32)) return int'(DIST_SAT);
        return int'(int_sqrt(sum << 16));
    endfunction

    // sorted k-nearest list; later candidates replace only on strictly smaller distance
    function automatic void find_nearest(t_point c, int skip, int k);
        int n;
        int pos;
        int unsigned d;
        n = 0;
        for (int a = 0; a < k; a++) begin
            near_idx[a] = 0;
            near_d[a]   = 0;
        end
        for (int a = 0; a < n_stored; a++) begin
            if (a == skip) continue;
            d = point_dist(c, store[a]);
            if (n < k) begin
                pos = n;
                n++;
            end else if (d < near_d[k-1]) begin
                pos = k - 1;
            end else begin
                continue;
            end
            while (pos > 0 && near_d[pos-1] > d) begin
                near_idx[pos] = near_idx[pos-1];
                near_d[pos]   = near_d[pos-1];
                pos--;
            end
            near_idx[pos] = a;
            near_d[pos]   = d;
        end
    endfunction

    function automatic longint unsigned reach_total(int k);
        longint unsigned s;
        int unsigned kd;
        s = 0;
        for (int i = 0; i < k; i++) begin
            kd = kdist[near_idx[i]];
            s += (near_d[i] > kd) ? near_d[i] : kd;
        end
        return s;
    endfunction

    function automatic int unsigned lof_score(int k);
        longint unsigned sq;
        longint unsigned so;
        longint unsigned total;
        longint unsigned lof;
        int q_idx[KMAX];
        for (int i = 0; i < n_stored; i++) begin
            find_nearest(store[i], i, k);
            kdist[i] = near_d[k-1];
        end
        find_nearest(query_pt, NPTS, k);
        sq = reach_total(k);
        for (int i = 0; i < k; i++) q_idx[i] = near_idx[i];
        total = 0;
        for (int i = 0; i < k; i++) begin
            find_nearest(store[q_idx[i]], q_idx[i], k);
            so = reach_total(k);
            if (so == 0) begin
                if (sq != 0) return int'(LOF_SAT);
                total += ONE_Q8;
            end else begin
                total += (sq << 8) / so;
            end
        end
        lof = total / k;
        return (lof > LOF_SAT) ? int'(LOF_SAT) : int'(lof);
    endfunction

    function automatic void predict_item(logic [KIND_W-1:0] kind, logic lab, t_point p);
        int k;
        int unsigned lof;
        t_lof_result r;
        case (kind)
            KIND_CLEAR: n_stored = 0;
            KIND_TRAIN: begin
                if (!lab && n_stored < NPTS) begin
                    store[n_stored] = p;
                    n_stored++;
                end
            end
            KIND_QUERY: begin
                query_pt = p;
                k = (k_reg > KMAX) ? KMAX : int'(k_reg);
                if (k == 0 || k >= n_stored) lof = ONE_Q8;
                else lof = lof_score(k);
                r.lof     = lof[LOF_W-1:0];
                r.outlier = (int'(lof) < 256 - int'(dev_reg)) ||
                            (int'(lof) > 256 + int'(dev_reg));
                sb.note_query(r);
            end
            default: ;
        endcase
    endfunction

    // called and returns at a falling edge; valid is left high after the item
    task automatic send_item(logic [KIND_W-1:0] kind, logic lab, t_point p);
        while ($urandom_range(99) < src_idle) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.kind            <= kind;
        in_ch.labeled_anomaly <= lab;
        in_ch.coord_0         <= p[15:0];
        in_ch.coord_1         <= p[31:16];
        in_ch.coord_2         <= p[47:32];
        in_ch.coord_3         <= p[63:48];
        do @(posedge i_clk); while (!in_ch.ready);
        predict_item(kind, lab, p);
        @(negedge i_clk);
    endtask

    // sender holds off until every pending result is back
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_NEIGHBOR_COUNT: k_reg    = data[4:0];
            CFG_DEVIATION:      dev_reg  = data;
            CFG_DIMS_IN_USE:    dims_reg = data[2:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    function automatic t_point near_point(int base, int spread);
        t_point p;
        for (int d = 0; d < 4; d++)
            p[16*d +: 16] = 16'(base + $urandom_range(0, 2 * spread) - spread);
        return p;
    endfunction

    function automatic t_point wide_point();
        return {$urandom(), $urandom()};
    endfunction

    initial begin
        int   items;
        int   n;
        int   nq;
        int   base;
        int   spread;
        bit   wide;
        t_point p;

        sb       = new();
        cycles   = 0;
        src_idle = 9;
        snk_idle = 80;
        i_rst_n  = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.kind  = KIND_CLEAR;
        in_ch.labeled_anomaly = 1'b0;
        in_ch.coord_0 = '0;
        in_ch.coord_1 = '0;
        in_ch.coord_2 = '0;
        in_ch.coord_3 = '0;
        k_reg    = RST_NEIGHBOR_COUNT;
        dev_reg  = RST_DEVIATION;
        dims_reg = RST_DIMS_IN_USE;
        n_stored = 0;
        query_pt = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty store, ignored kind, extremes, ties and zero reach sums
        send_item(KIND_QUERY, 1'b0, '0);
        send_item(2'd3, 1'b1, {4{16'hFFFF}});
        send_item(KIND_CLEAR, 1'b1, '0);
        for (int i = 0; i < 6; i++) send_item(KIND_TRAIN, 1'b0, near_point(0, 20));
        send_item(KIND_TRAIN, 1'b1, {4{16'h8000}});
        send_item(KIND_TRAIN, 1'b0, {4{16'h7FFF}});
        send_item(KIND_QUERY, 1'b0, near_point(5, 10));
        send_item(KIND_QUERY, 1'b0, {4{16'h8000}});
        drain();
        write_cfg(CFG_NEIGHBOR_COUNT, 16'd31);
        write_cfg(CFG_DIMS_IN_USE, 16'd0);
        write_cfg(CFG_DEVIATION, 16'd0);
        send_item(KIND_QUERY, 1'b0, near_point(0, 20));
        drain();
        write_cfg(CFG_NEIGHBOR_COUNT, 16'd1);
        write_cfg(CFG_DIMS_IN_USE, 16'd7);
        write_cfg(CFG_DEVIATION, 16'hFFFF);
        send_item(KIND_QUERY, 1'b0, near_point(0, 20));
        send_item(KIND_CLEAR, 1'b0, '0);
        for (int i = 0; i < 3; i++) send_item(KIND_TRAIN, 1'b0, {4{16'd100}});
        send_item(KIND_QUERY, 1'b0, {4{16'd100}});
        send_item(KIND_QUERY, 1'b0, {4{16'd90}});
        drain();
        write_cfg(CFG_NEIGHBOR_COUNT, 16'd0);
        write_cfg(CFG_DEVIATION, 16'd256);
        send_item(KIND_QUERY, 1'b0, {4{16'd90}});
        drain();

        // random: clear, a small training set, then a few queries
        items = 0;
        while (items < 100) begin
            if (items >= 66) begin
                src_idle = 0;
                snk_idle = 0;
            end else if (items >= 33) begin
                src_idle = 80;
                snk_idle = 9;
            end
            drain();
            write_cfg(CFG_NEIGHBOR_COUNT, 16'($urandom_range(0, 20)));
            write_cfg(CFG_DEVIATION, ($urandom_range(3) == 0) ? 16'($urandom()) :
                                     16'($urandom_range(0, 300)));
            write_cfg(CFG_DIMS_IN_USE, 16'($urandom_range(0, 7)));
            wide   = ($urandom_range(4) == 0);
            base   = $urandom_range(0, 60000) - 30000;
            spread = $urandom_range(1, 400);
            n      = $urandom_range(2, 18);
            nq     = $urandom_range(1, 4);
            send_item(KIND_CLEAR, 1'($urandom()), wide_point());
            items++;
            for (int i = 0; i < n; i++) begin
                p = wide ? wide_point() : near_point(base, spread);
                send_item(KIND_TRAIN, ($urandom_range(5) == 0), p);
                items++;
            end
            for (int i = 0; i < nq; i++) begin
                if ($urandom_range(7) == 0)
                    send_item(2'd3, 1'($urandom()), wide_point());
                p = wide ? wide_point() : near_point(base, spread * 2);
                send_item(KIND_QUERY, 1'($urandom()), p);
                items++;
            end
        end

        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/lof_det_pkg.sv
rtl/lof_det_if.sv
rtl/lof_det_dist.sv
rtl/lof_det_div.sv
rtl/lof_det_cell.sv
rtl/local_outlier_factor_detector_unit.sv
test/local_outlier_factor_detector_unit_tb.sv
